// ===== rtl/cre_pkg.sv =====
// Shared types and constants for the Catmull-Rom point evaluator.
package cre_pkg;

  localparam int FIELD_W = 32;
  localparam int IDX_W   = 6;
  localparam int FRAC_W  = 16;
  localparam int CNT_W   = 7;

  localparam logic [CNT_W-1:0] PC_RESET   = 7'd64;
  localparam int               MIN_POINTS = 6;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;

  localparam logic [2:0] MUL_TT  = 3'd0;
  localparam logic [2:0] MUL_T2T = 3'd1;
  localparam logic [2:0] MUL_CA  = 3'd2;
  localparam logic [2:0] MUL_CB  = 3'd3;
  localparam logic [2:0] MUL_CC  = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       wr;
    logic       load;
    logic [1:0] rd_k;
    logic       cap_en;
    logic [1:0] cap_k;
    logic       mul_en;
    logic [2:0] mul_op;
    logic       t2_ld;
    logic       t3_ld;
    logic       coef_ld;
    logic [1:0] axis;
    logic       acc_add;
    logic       fin;
    logic       publish;
  } cmd_t;

endpackage

// ===== rtl/cre_ifs.sv =====
// Input and output channel interfaces of the point evaluator.
interface cre_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [5:0]         index;
  logic [15:0]        frac_where;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, action, index, frac_where, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, action, index, frac_where, point_x, point_y, point_z,
                output ready);
endinterface

interface cre_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== rtl/catmull_rom_point_eval.sv =====
// Top level of the Catmull-Rom point evaluator with its configuration port.
// A write item is taken in the idle state; the next item can follow at once.
// A query item keeps the block busy until its result is published, so the next item
// waits for the query to finish and the output to be free, paced by the single-port table reads and the
// one multiplier shared over t^2, t^3 and three coefficient products per axis.
// Reset clears the sequencer and output valid and sets point_count to 64; the
// point tables are not cleared.
module catmull_rom_point_eval
  import cre_pkg::*;
#(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  cre_in_if.sink      in_ch,
  cre_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0] point_count;
  logic             cfg_wr;
  cmd_t             cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= PC_RESET;
    end else if (cfg_wr && paddr[2] == REG_POINT_COUNT) begin
      point_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count) : '0;

  cre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  cre_dp #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .index       (in_ch.index),
    .frac_where  (in_ch.frac_where),
    .point_x     (in_ch.point_x),
    .point_y     (in_ch.point_y),
    .point_z     (in_ch.point_z),
    .point_count (point_count),
    .out_x       (out_ch.out_x),
    .out_y       (out_ch.out_y),
    .out_z       (out_ch.out_z)
  );

endmodule

// ===== rtl/cre_ram.sv =====
// Single-port RAM with registered read.
module cre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/cre_ctrl.sv =====
// Sequencer for table reads, shared multiplier steps and result hand-off.
module cre_ctrl
  import cre_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_action,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_RD3  = 4'd4;
  localparam logic [3:0] S_RD4  = 4'd5;
  localparam logic [3:0] S_COEF = 4'd6;
  localparam logic [3:0] S_M0   = 4'd7;
  localparam logic [3:0] S_M1   = 4'd8;
  localparam logic [3:0] S_M2   = 4'd9;
  localparam logic [3:0] S_M3   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] axis, axis_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_QUERY) begin
            cmd.load   = 1'b1;
            state_next = S_RD0;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_RD0: begin
        cmd.rd_k   = 2'd0;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_TT;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_k   = 2'd1;
        cmd.cap_en = 1'b1;
        cmd.cap_k  = 2'd0;
        cmd.t2_ld  = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_k   = 2'd2;
        cmd.cap_en = 1'b1;
        cmd.cap_k  = 2'd1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_T2T;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.rd_k   = 2'd3;
        cmd.cap_en = 1'b1;
        cmd.cap_k  = 2'd2;
        cmd.t3_ld  = 1'b1;
        state_next = S_RD4;
      end
      S_RD4: begin
        cmd.cap_en = 1'b1;
        cmd.cap_k  = 2'd3;
        axis_next  = AXIS_X;
        state_next = S_COEF;
      end
      S_COEF: begin
        cmd.coef_ld = 1'b1;
        state_next  = S_M0;
      end
      S_M0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_CA;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = MUL_CB;
        cmd.acc_add = 1'b1;
        state_next  = S_M2;
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = MUL_CC;
        cmd.acc_add = 1'b1;
        state_next  = S_M3;
      end
      S_M3: begin
        cmd.fin = 1'b1;
        if (axis == AXIS_Z) begin
          state_next = S_DONE;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_COEF;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= AXIS_X;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result published over a pending item");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (axis != 2'd3))
    else $error("axis counter out of range");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_action == ACT_QUERY) |=> !cmd.publish)
    else $error("result published right after query accept");

  a_last_axis_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin && axis == AXIS_Z) |=> (state == S_DONE))
    else $error("last axis did not finish the query");

endmodule

// ===== rtl/cre_dp.sv =====
// Datapath: point tables, section clamp, shared multiplier and accumulators.
module cre_dp
  import cre_pkg::*;
#(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                      clk,
  input  cmd_t                      cmd,
  input  logic [IDX_W-1:0]          index,
  input  logic [FRAC_W-1:0]         frac_where,
  input  logic signed [FIELD_W-1:0] point_x,
  input  logic signed [FIELD_W-1:0] point_y,
  input  logic signed [FIELD_W-1:0] point_z,
  input  logic [CNT_W-1:0]          point_count,
  output logic signed [FIELD_W-1:0] out_x,
  output logic signed [FIELD_W-1:0] out_y,
  output logic signed [FIELD_W-1:0] out_z
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = ($clog2(MAX_POINTS + 1) > CNT_W) ? $clog2(MAX_POINTS + 1) : CNT_W;
  localparam int CFW = COORD_WIDTH + 4;
  localparam int MBW = FRAC_W + 1;
  localparam int PW  = CFW + MBW;

  logic [NW-1:0] idx_ext, pc_ext, n_clamp, sec;
  logic [AW-1:0] base, addr;
  logic          we;
  logic [COORD_WIDTH-1:0] wx, wy, wz, rx, ry, rz;

  logic [FRAC_W-1:0] t, t2, t3;
  logic signed [COORD_WIDTH-1:0] pts [3][4];
  logic signed [COORD_WIDTH-1:0] pa, pb, pc, pd;
  logic signed [CFW-1:0] ea, eb, ec, ed;
  logic signed [CFW-1:0] ca, cb, cc;
  logic signed [CFW-1:0] ma;
  logic signed [MBW-1:0] mb;
  logic signed [PW-1:0]  prod;
  logic signed [COORD_WIDTH-1:0] acc, prod_sh;
  logic signed [COORD_WIDTH-1:0] res [3];

  assign idx_ext = NW'(index);
  assign pc_ext  = NW'(point_count);

  always_comb begin
    if (pc_ext < NW'(MIN_POINTS)) begin
      n_clamp = NW'(MIN_POINTS);
    end else if (pc_ext > NW'(MAX_POINTS)) begin
      n_clamp = NW'(MAX_POINTS);
    end else begin
      n_clamp = pc_ext;
    end
    if (idx_ext < NW'(1)) begin
      sec = NW'(1);
    end else if (idx_ext > n_clamp - NW'(3)) begin
      sec = n_clamp - NW'(3);
    end else begin
      sec = idx_ext;
    end
  end

  assign we   = cmd.wr && (idx_ext < NW'(MAX_POINTS));
  assign addr = cmd.wr ? idx_ext[AW-1:0] : base + AW'(cmd.rd_k);
  assign wx   = COORD_WIDTH'(point_x);
  assign wy   = COORD_WIDTH'(point_y);
  assign wz   = COORD_WIDTH'(point_z);

  cre_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(we), .addr(addr), .wdata(wx), .rdata(rx)
  );
  cre_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(we), .addr(addr), .wdata(wy), .rdata(ry)
  );
  cre_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_POINTS)) u_ram_z (
    .clk(clk), .we(we), .addr(addr), .wdata(wz), .rdata(rz)
  );

  assign pa = pts[cmd.axis][0];
  assign pb = pts[cmd.axis][1];
  assign pc = pts[cmd.axis][2];
  assign pd = pts[cmd.axis][3];
  assign ea = CFW'(pa);
  assign eb = CFW'(pb);
  assign ec = CFW'(pc);
  assign ed = CFW'(pd);

  always_comb begin
    case (cmd.mul_op)
      MUL_TT: begin
        ma = CFW'($signed({1'b0, t}));
        mb = $signed({1'b0, t});
      end
      MUL_T2T: begin
        ma = CFW'($signed({1'b0, t2}));
        mb = $signed({1'b0, t});
      end
      MUL_CA: begin
        ma = ca;
        mb = $signed({1'b0, t3});
      end
      MUL_CB: begin
        ma = cb;
        mb = $signed({1'b0, t2});
      end
      MUL_CC: begin
        ma = cc;
        mb = $signed({1'b0, t});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_sh = prod[COORD_WIDTH+16:17];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= AW'(sec - NW'(1));
      t    <= frac_where;
    end
    if (cmd.cap_en) begin
      pts[0][cmd.cap_k] <= rx;
      pts[1][cmd.cap_k] <= ry;
      pts[2][cmd.cap_k] <= rz;
    end
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
    if (cmd.t2_ld) begin
      t2 <= prod[31:16];
    end
    if (cmd.t3_ld) begin
      t3 <= prod[31:16];
    end
    if (cmd.coef_ld) begin
      ca  <= (eb <<< 1) + eb + ed - ea - (ec <<< 1) - ec;
      cb  <= (ea <<< 1) - (eb <<< 2) - eb + (ec <<< 2) - ed;
      cc  <= ec - ea;
      acc <= pb;
    end else if (cmd.acc_add) begin
      acc <= acc + prod_sh;
    end
    if (cmd.fin) begin
      res[cmd.axis] <= acc + prod_sh;
    end
    if (cmd.publish) begin
      out_x <= FIELD_W'(res[0]);
      out_y <= FIELD_W'(res[1]);
      out_z <= FIELD_W'(res[2]);
    end
  end

endmodule

// ===== tb/catmull_rom_point_eval_checker.sv =====
`timescale 1ns / 100ps
// Watches the item channels and register port, predicts each interpolated point and compares.
module catmull_rom_point_eval_checker
  import cre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cre_in_if           in_ch,
  cre_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          backlog
);

  localparam int TABLE_DEPTH = 64;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic signed [31:0] tab_x [TABLE_DEPTH];
  logic signed [31:0] tab_y [TABLE_DEPTH];
  logic signed [31:0] tab_z [TABLE_DEPTH];
  logic [CNT_W-1:0]   count;
  point_t             expected_points [$];
  int                 mismatches = 0;

  function automatic logic [31:0] spline_axis(logic signed [31:0] a, logic signed [31:0] b,
                                              logic signed [31:0] c, logic signed [31:0] d,
                                              longint t, longint t2, longint t3);
    longint pa;
    longint pb;
    longint pc;
    longint pd;
    longint ka;
    longint kb;
    longint kc;
    longint sum;
    pa  = a;
    pb  = b;
    pc  = c;
    pd  = d;
    ka  = 3 * pb + pd - pa - 3 * pc;
    kb  = 2 * pa - 5 * pb + 4 * pc - pd;
    kc  = pc - pa;
    sum = ((ka * t3) >>> 17) + ((kb * t2) >>> 17) + ((kc * t) >>> 17) + pb;
    return sum[31:0];
  endfunction

  function automatic point_t interpolate(logic [IDX_W-1:0] section, logic [FRAC_W-1:0] frac);
    int     n;
    int     s;
    longint t;
    longint t2;
    longint t3;
    point_t p;
    n = count;
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    s = section;
    if (s < 1) s = 1;
    if (s > n - 3) s = n - 3;
    t  = frac;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    p.x = spline_axis(tab_x[s-1], tab_x[s], tab_x[s+1], tab_x[s+2], t, t2, t3);
    p.y = spline_axis(tab_y[s-1], tab_y[s], tab_y[s+1], tab_y[s+2], t, t2, t3);
    p.z = spline_axis(tab_z[s-1], tab_z[s], tab_z[s+1], tab_z[s+2], t, t2, t3);
    return p;
  endfunction

  always @(posedge clk) begin : watch
    point_t got;
    point_t want;
    if (rst) begin
      count = PC_RESET;
      expected_points.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_POINT_COUNT, 2'b00}) begin
        count = pwdata[CNT_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_x, out_ch.out_y, out_ch.out_z};
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("unexpected point x=%h y=%h z=%h", got.x, got.y, got.z);
          end
        end else begin
          want = expected_points.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("point mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                       want.x, want.y, want.z, got.x, got.y, got.z);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_WRITE) begin
          tab_x[in_ch.index] = in_ch.point_x;
          tab_y[in_ch.index] = in_ch.point_y;
          tab_z[in_ch.index] = in_ch.point_z;
        end else begin
          expected_points.push_back(interpolate(in_ch.index, in_ch.frac_where));
        end
      end
    end
    errors  <= mismatches;
    backlog <= expected_points.size();
  end

endmodule

// ===== tb/catmull_rom_point_eval_test.sv =====
`timescale 1ns / 100ps
// Top of the point evaluator regression: clock, reset, stimulus and verdict.
module catmull_rom_point_eval_test;
  import cre_pkg::*;

  localparam int         HOLD_CYCLES  = 400;
  localparam int         HOLD_AFTER   = 150;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 250;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [2:0] ADDR_POINT_COUNT = {REG_POINT_COUNT, 2'b00};
  localparam logic [2:0] ADDR_UNUSED      = 3'd4;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          backlog;
  int          cycles;
  bit          calm;
  bit [63:0]   loaded;
  int          active_count;

  cre_in_if  in_ch ();
  cre_out_if out_ch ();

  catmull_rom_point_eval u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  catmull_rom_point_eval_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .backlog (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("catmull_rom_point_eval regression: fail");
    $finish;
  end

  initial begin : receiver
    int taken;
    int hold_left;
    bit held;
    taken        = 0;
    hold_left    = 0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held && taken >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic int section_of(logic [IDX_W-1:0] idx);
    int n;
    int s;
    n = active_count;
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > 64) n = 64;
    s = idx;
    if (s < 1) s = 1;
    if (s > n - 3) s = n - 3;
    return s;
  endfunction

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_POINT_COUNT) active_count = data[CNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic push_item(logic act, logic [IDX_W-1:0] idx, logic [FRAC_W-1:0] frac,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.index      <= idx;
    in_ch.frac_where <= frac;
    in_ch.point_x    <= px;
    in_ch.point_y    <= py;
    in_ch.point_z    <= pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act == ACT_WRITE) loaded[idx] = 1'b1;
  endtask

  // A query whose four points are not all loaded turns into a write of the first missing one.
  task automatic random_item();
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] frac;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       pz;
    int                s;
    int                k;
    idx  = IDX_W'($urandom);
    frac = pick_frac();
    px   = pick_coord();
    py   = pick_coord();
    pz   = pick_coord();
    if ($urandom_range(99) < 50) begin
      s = section_of(idx);
      for (k = s - 1; k <= s + 2; k++) begin
        if (!loaded[k]) begin
          push_item(ACT_WRITE, IDX_W'(k), frac, px, py, pz);
          return;
        end
      end
      push_item(ACT_QUERY, idx, frac, px, py, pz);
    end else begin
      push_item(ACT_WRITE, idx, frac, px, py, pz);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          phase;
    int          i;
    logic [6:0]  setting;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_WRITE;
    in_ch.index      = '0;
    in_ch.frac_where = '0;
    in_ch.point_x    = '0;
    in_ch.point_y    = '0;
    in_ch.point_z    = '0;
    calm             = 1'b0;
    loaded           = '0;
    active_count     = PC_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(ADDR_UNUSED, 32'd9);
    write_reg(ADDR_POINT_COUNT, 32'd6);

    push_item(ACT_WRITE, 6'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    push_item(ACT_WRITE, 6'd1, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_item(ACT_WRITE, 6'd2, 16'h8000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    push_item(ACT_WRITE, 6'd3, 16'h0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_item(ACT_WRITE, 6'd4, 16'h1234, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    push_item(ACT_WRITE, 6'd5, 16'hFFFF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000);
    push_item(ACT_QUERY, 6'd0, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(ACT_QUERY, 6'd1, 16'hFFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_QUERY, 6'd2, 16'h8000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_QUERY, 6'd3, 16'h0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_QUERY, 6'd63, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    push_item(ACT_QUERY, 6'd4, 16'd12345, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_QUERY, 6'd0, 16'hFFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_WRITE, 6'd2, 16'hFFFF, 32'hFFFE_0000, 32'h0003_8000, 32'h8000_0001);
    push_item(ACT_QUERY, 6'd1, 16'd40000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_item(ACT_QUERY, 6'd2, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: setting = 7'd64;
        1: setting = 7'd127;
        2: setting = 7'd0;
        3: setting = 7'd5;
        4: setting = 7'd6;
        5: setting = 7'd33;
        default: setting = 7'($urandom_range(127));
      endcase
      write_reg(ADDR_POINT_COUNT, {25'd0, setting});
      calm = (phase == 2);
      for (i = 0; i < PHASE_ITEMS; i++) random_item();
    end
    drain();

    if (errors == 0) begin
      $display("catmull_rom_point_eval regression: pass");
    end else begin
      $display("catmull_rom_point_eval regression: fail");
    end
    $finish;
  end

endmodule
